// ===== design/amt_pkg.sv =====
// Shared types, constants and helpers for the box transform block.
`timescale 1ns / 1ps
package amt_pkg;

    localparam int CORNER_COUNT = 8;
    localparam int CORNER_W     = 3;
    localparam int ACC_W        = 50;
    localparam int PAIR_COUNT   = 8;
    localparam int IDX_W        = 4;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef logic [PAIR_COUNT-1:0][63:0] t_mat;

    typedef struct packed {
        logic first;
        logic last;
    } t_meta;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
    } t_box;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
        logic               fault;
    } t_result;

    // Matrix entry at column col, row row of the column-major register pairs.
    function automatic logic signed [31:0] mat_entry(t_mat m, int unsigned col,
                                                    int unsigned row);
        logic [63:0] pair;
        pair = m[{col[1:0], row[1]}];
        return row[0] ? $signed(pair[63:32]) : $signed(pair[31:0]);
    endfunction

endpackage

// ===== design/aabb_matrix_transform.sv =====
// Top level: input queue, corner sequencer, transform and divide lanes, min/max, result queue.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  input    | i_push / o_full    | i_min_x..i_max_z, six signed Q16.16 words
//  result   | o_empty / i_pop    | o_out_min_x..o_out_max_z, o_divide_fault
//  config   | i_cfg_we           | i_cfg_idx, i_cfg_data (64-bit matrix pair)
//
// The back issues one corner per cycle while the input queue holds a box and, at a
// box's first corner, a result credit is free; boxes follow back to back. Reset clears
// queues and loads the identity matrix.
// A box starts only when the result queue has room for it, so the lanes never stall.
`timescale 1ns / 1ps
module aabb_matrix_transform import amt_pkg::*; #(
    parameter int IN_DEPTH  = 2,
    parameter int OUT_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic signed [31:0] i_min_x,
    input  logic signed [31:0] i_min_y,
    input  logic signed [31:0] i_min_z,
    input  logic signed [31:0] i_max_x,
    input  logic signed [31:0] i_max_y,
    input  logic signed [31:0] i_max_z,
    output logic               o_empty,
    input  logic               i_pop,
    output logic signed [31:0] o_out_min_x,
    output logic signed [31:0] o_out_min_y,
    output logic signed [31:0] o_out_min_z,
    output logic signed [31:0] o_out_max_x,
    output logic signed [31:0] o_out_max_y,
    output logic signed [31:0] o_out_max_z,
    output logic               o_divide_fault,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [63:0]        i_cfg_data
);
    localparam int CREDIT_W = $clog2(OUT_DEPTH + 1);

    // Matrix registers, identity on reset.
    t_mat r_mat;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat    <= '0;
            r_mat[0] <= 64'h0000_0000_0001_0000;
            r_mat[2] <= 64'h0001_0000_0000_0000;
            r_mat[5] <= 64'h0000_0000_0001_0000;
            r_mat[7] <= 64'h0001_0000_0000_0000;
        end else if (i_cfg_we && (i_cfg_idx < IDX_W'(PAIR_COUNT))) begin
            r_mat[i_cfg_idx[CORNER_W-1:0]] <= i_cfg_data;
        end
    end

    // Front: queue the boxes.
    t_box in_box, cur_box;
    logic in_empty, issue, last_corner;
    logic [$bits(t_box)-1:0] cur_bits;

    assign in_box = '{min_x: i_min_x, min_y: i_min_y, min_z: i_min_z,
                      max_x: i_max_x, max_y: i_max_y, max_z: i_max_z};

    amt_fifo #(.WIDTH($bits(t_box)), .DEPTH(IN_DEPTH)) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push),
        .i_data  (in_box),
        .i_rd    (issue && last_corner),
        .o_data  (cur_bits),
        .o_full  (o_full),
        .o_empty (in_empty)
    );
    assign cur_box = t_box'(cur_bits);

    // Back: corner sequencer with result credits.
    logic [CORNER_W-1:0] r_corner;
    logic [CREDIT_W-1:0] r_credit;
    logic                out_pop, out_push;

    assign last_corner = (r_corner == CORNER_W'(CORNER_COUNT - 1));
    assign issue = !in_empty && ((r_corner != '0) || (r_credit < CREDIT_W'(OUT_DEPTH)));
    assign out_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= '0;
            r_credit <= '0;
        end else begin
            if (issue) begin
                r_corner <= r_corner + 1'b1;
            end
            if ((issue && (r_corner == '0)) && !out_pop) begin
                r_credit <= r_credit + 1'b1;
            end else if (!(issue && (r_corner == '0)) && out_pop) begin
                r_credit <= r_credit - 1'b1;
            end
        end
    end

    logic signed [31:0] pt [3];
    t_meta              iss_meta;
    assign pt[0] = r_corner[0] ? cur_box.max_x : cur_box.min_x;
    assign pt[1] = r_corner[1] ? cur_box.max_y : cur_box.min_y;
    assign pt[2] = r_corner[2] ? cur_box.max_z : cur_box.min_z;
    assign iss_meta = '{first: (r_corner == '0), last: last_corner};

    logic                    c_valid;
    t_meta                   c_meta;
    logic signed [ACC_W-1:0] c_acc [4];

    amt_corner u_corner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (issue),
        .i_meta  (iss_meta),
        .i_pt    (pt),
        .i_mat   (r_mat),
        .o_valid (c_valid),
        .o_meta  (c_meta),
        .o_acc   (c_acc)
    );

    logic               d_valid [3];
    t_meta              d_meta [3];
    logic signed [31:0] d_quot [3];
    logic               d_fault [3];

    for (genvar a = 0; a < 3; a++) begin : g_lane
        amt_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid),
            .i_meta  (c_meta),
            .i_num   (c_acc[a]),
            .i_den   (c_acc[3]),
            .o_valid (d_valid[a]),
            .o_meta  (d_meta[a]),
            .o_quot  (d_quot[a]),
            .o_fault (d_fault[a])
        );
    end

    // Fold corners into the running box; lanes run in lockstep.
    logic signed [31:0] r_min [3], r_max [3];
    logic signed [31:0] n_min [3], n_max [3];
    logic               r_fault, n_fault;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (d_meta[0].first) begin
                n_min[a] = d_quot[a];
                n_max[a] = d_quot[a];
            end else begin
                n_min[a] = (d_quot[a] < r_min[a]) ? d_quot[a] : r_min[a];
                n_max[a] = (d_quot[a] > r_max[a]) ? d_quot[a] : r_max[a];
            end
        end
        n_fault = d_fault[0] || (!d_meta[0].first && r_fault);
    end

    always_ff @(posedge i_clk) begin
        if (d_valid[0]) begin
            r_min   <= n_min;
            r_max   <= n_max;
            r_fault <= n_fault;
        end
    end

    assign out_push = d_valid[0] && d_meta[0].last && d_valid[1] && d_valid[2];

    t_result res_in, res_out;
    logic    out_full;
    logic [$bits(t_result)-1:0] res_bits;

    assign res_in = '{min_x: n_min[0], min_y: n_min[1], min_z: n_min[2],
                      max_x: n_max[0], max_y: n_max[1], max_z: n_max[2],
                      fault: n_fault};

    amt_fifo #(.WIDTH($bits(t_result)), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (out_push && !out_full),
        .i_data  (res_in),
        .i_rd    (i_pop),
        .o_data  (res_bits),
        .o_full  (out_full),
        .o_empty (o_empty)
    );
    assign res_out = t_result'(res_bits);

    assign o_out_min_x    = res_out.min_x;
    assign o_out_min_y    = res_out.min_y;
    assign o_out_min_z    = res_out.min_z;
    assign o_out_max_x    = res_out.max_x;
    assign o_out_max_y    = res_out.max_y;
    assign o_out_max_z    = res_out.max_z;
    assign o_divide_fault = res_out.fault;
endmodule

// ===== design/amt_fifo.sv =====
// Small register queue used between the front, the back and the result port.
`timescale 1ns / 1ps
module amt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ===== design/amt_corner.sv =====
// Corner transform: twelve products, floor to Q16.16, row sums with translation.
`timescale 1ns / 1ps
module amt_corner import amt_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_meta                   i_meta,
    input  logic signed [31:0]      i_pt [3],
    input  t_mat                    i_mat,
    output logic                    o_valid,
    output t_meta                   o_meta,
    output logic signed [ACC_W-1:0] o_acc [4]
);
    logic signed [63:0]      r_prod [4][3];
    logic signed [31:0]      r_trans [4];
    logic                    r_v1, r_v2;
    t_meta                   r_meta1, r_meta2;
    logic signed [ACC_W-1:0] r_acc [4];
    logic signed [ACC_W-1:0] n_acc [4];

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[r][c] <= mat_entry(i_mat, c, r) * i_pt[c];
            end
            r_trans[r] <= mat_entry(i_mat, 3, r);
        end
        r_meta1 <= i_meta;
    end

    // An arithmetic shift of the exact product rounds toward minus infinity.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_acc[r] = ACC_W'(r_prod[r][0] >>> 16) + ACC_W'(r_prod[r][1] >>> 16)
                     + ACC_W'(r_prod[r][2] >>> 16) + ACC_W'(r_trans[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_meta2 <= r_meta1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_meta  = r_meta2;
    assign o_acc   = r_acc;
endmodule

// ===== design/amt_div.sv =====
// Pipelined Q16.16 divider lane, one quotient bit per stage, with saturation.
`timescale 1ns / 1ps
module amt_div import amt_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  t_meta                   i_meta,
    input  logic signed [ACC_W-1:0] i_num,
    input  logic signed [ACC_W-1:0] i_den,
    output logic                    o_valid,
    output t_meta                   o_meta,
    output logic signed [31:0]      o_quot,
    output logic                    o_fault
);
    localparam int STEPS = 32;

    typedef struct packed {
        t_meta meta;
        logic  neg;
        logic  zero;
        logic  num_pos;
        logic  num_neg;
        logic  ovf;
    } t_dflags;

    // Stage A: magnitudes and signs.
    logic               r_va;
    t_dflags            r_fa;
    logic [ACC_W-1:0]   r_abs_a, r_abs_b;

    always_ff @(posedge i_clk) begin
        r_abs_a         <= i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
        r_abs_b         <= i_den[ACC_W-1] ? ACC_W'(-i_den) : ACC_W'(i_den);
        r_fa.meta       <= i_meta;
        r_fa.neg        <= i_num[ACC_W-1] ^ i_den[ACC_W-1];
        r_fa.zero       <= (i_den == '0);
        r_fa.num_pos    <= !i_num[ACC_W-1] && (i_num != '0);
        r_fa.num_neg    <= i_num[ACC_W-1];
        r_fa.ovf        <= 1'b0;
    end

    // Stage B onward: steps of restoring division.
    logic               r_v [STEPS+1];
    t_dflags            r_f [STEPS+1];
    logic [ACC_W-1:0]   r_r [STEPS+1];
    logic [ACC_W-1:0]   r_b [STEPS+1];
    logic [31:0]        r_x [STEPS+1];

    // Quotient beyond 16 integer bits saturates.
    always_ff @(posedge i_clk) begin
        r_f[0]     <= '{meta: r_fa.meta, neg: r_fa.neg, zero: r_fa.zero,
                        num_pos: r_fa.num_pos, num_neg: r_fa.num_neg,
                        ovf: ({16'h0, r_abs_a} >= {r_abs_b, 16'h0})};
        r_r[0]     <= ACC_W'(r_abs_a >> 16);
        r_x[0]     <= {r_abs_a[15:0], 16'h0};
        r_b[0]     <= r_abs_b;
    end

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        logic [ACC_W:0] trial;
        logic           ge;
        assign trial = {r_r[s], r_x[s][31]};
        assign ge    = (trial >= {1'b0, r_b[s]});
        always_ff @(posedge i_clk) begin
            r_r[s+1] <= ge ? ACC_W'(trial - {1'b0, r_b[s]}) : ACC_W'(trial);
            r_x[s+1] <= {r_x[s][30:0], ge};
            r_b[s+1] <= r_b[s];
            r_f[s+1] <= r_f[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            for (int s = 0; s <= STEPS; s++) begin
                r_v[s] <= 1'b0;
            end
        end else begin
            r_va   <= i_valid;
            r_v[0] <= r_va;
            for (int s = 0; s < STEPS; s++) begin
                r_v[s+1] <= r_v[s];
            end
        end
    end

    // Final stage: sign and saturation.
    logic               r_vo;
    t_meta              r_meta_o;
    logic signed [31:0] r_quot, n_quot;
    logic               r_fault;
    t_dflags            ff;
    logic [31:0]        q;

    assign ff = r_f[STEPS];
    assign q  = r_x[STEPS];

    always_comb begin
        if (ff.zero) begin
            n_quot = ff.num_pos ? Q_MAX : (ff.num_neg ? Q_MIN : '0);
        end else if (ff.ovf) begin
            n_quot = ff.neg ? Q_MIN : Q_MAX;
        end else if (ff.neg) begin
            n_quot = (q > 32'h8000_0000) ? Q_MIN : -$signed(q);
        end else begin
            n_quot = (q > 32'h7fff_ffff) ? Q_MAX : $signed(q);
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot   <= n_quot;
        r_fault  <= ff.zero;
        r_meta_o <= ff.meta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= r_v[STEPS];
        end
    end

    assign o_valid = r_vo;
    assign o_meta  = r_meta_o;
    assign o_quot  = r_quot;
    assign o_fault = r_fault;
endmodule

// ===== design/amt_checker.sv =====
// Port-level checks for the box transform, bound to the top level.
`timescale 1ns / 1ps
module amt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_pop,
    input logic               o_empty,
    input logic               o_full,
    input logic signed [31:0] o_out_min_x,
    input logic signed [31:0] o_out_min_y,
    input logic signed [31:0] o_out_min_z,
    input logic signed [31:0] o_out_max_x,
    input logic signed [31:0] o_out_max_y,
    input logic signed [31:0] o_out_max_z,
    input logic               o_divide_fault
);
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not cleared by reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_out_min_x)
            && $stable(o_out_max_z) && $stable(o_divide_fault)))
        else $error("waiting item changed");

    a_order_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_out_min_x <= o_out_max_x))
        else $error("x min above max");

    a_order_yz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> ((o_out_min_y <= o_out_max_y) && (o_out_min_z <= o_out_max_z)))
        else $error("y or z min above max");
endmodule

bind aabb_matrix_transform amt_checker u_amt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_pop          (i_pop),
    .o_empty        (o_empty),
    .o_full         (o_full),
    .o_out_min_x    (o_out_min_x),
    .o_out_min_y    (o_out_min_y),
    .o_out_min_z    (o_out_min_z),
    .o_out_max_x    (o_out_max_x),
    .o_out_max_y    (o_out_max_y),
    .o_out_max_z    (o_out_max_z),
    .o_divide_fault (o_divide_fault)
);

// ===== tb/tb_aabb_matrix_transform.sv =====
// Self-checking testbench for the box transform block: fixed-point prediction and scoreboard.
`timescale 1ns / 1ps
module tb_aabb_matrix_transform;
    import amt_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_push = 1'b0;
    logic               o_full;
    logic signed [31:0] i_min_x = '0, i_min_y = '0, i_min_z = '0;
    logic signed [31:0] i_max_x = '0, i_max_y = '0, i_max_z = '0;
    logic               o_empty;
    logic               i_pop = 1'b0;
    logic signed [31:0] o_out_min_x, o_out_min_y, o_out_min_z;
    logic signed [31:0] o_out_max_x, o_out_max_y, o_out_max_z;
    logic               o_divide_fault;
    logic               i_cfg_we = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx = '0;
    logic [63:0]        i_cfg_data = '0;

    aabb_matrix_transform DUT (.*);

    always #1 i_clk = ~i_clk;

    localparam int DRAIN_CYCLES = 80;
    localparam logic [63:0] ONE_LO = 64'h0000_0000_0001_0000;
    localparam logic [63:0] ONE_HI = 64'h0001_0000_0000_0000;

    int err_count = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
        err_count++;
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
    endtask

    // Projection predictor with its own copy of the matrix
    class box_scoreboard;
        logic [63:0] pairs [PAIR_COUNT];
        t_result     pending [$];
        int          checked;

        function void load_identity();
            pairs = '{ONE_LO, 64'd0, ONE_HI, 64'd0, 64'd0, ONE_LO, 64'd0, ONE_HI};
        endfunction

        function logic signed [63:0] entry(int col, int row);
            logic [63:0] p;
            p = pairs[col * 2 + row / 2];
            return (row % 2) ? {{32{p[63]}}, p[63:32]} : {{32{p[31]}}, p[31:0]};
        endfunction

        function logic signed [63:0] mul_down(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [63:0] p;
            p = a * b;
            return p >>> 16; // arithmetic shift floors toward minus infinity
        endfunction

        function logic signed [63:0] divide(logic signed [63:0] num, logic signed [63:0] den,
                                            inout logic fault);
            logic        neg;
            logic [63:0] a, b, q, r;
            if (den == 0) begin
                fault = 1'b1;
                return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 64'sd0);
            end
            neg = (num < 0) != (den < 0);
            a = num < 0 ? -num : num;
            b = den < 0 ? -den : den;
            q = a / b;
            r = a % b;
            if (q >= 64'd65536) return neg ? -64'sd2147483648 : 64'sd2147483647;
            for (int i = 0; i < 16; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= b) begin
                    r = r - b;
                    q[0] = 1'b1;
                end
            end
            if (neg) return q > 64'd2147483648 ? -64'sd2147483648 : -$signed(q);
            return q > 64'd2147483647 ? 64'sd2147483647 : $signed(q);
        endfunction

        function void note_box(t_box bx);
            logic signed [63:0] lo [3], hi [3], bmin [3], bmax [3], pt [3], acc [4], v;
            logic    fault;
            t_result res;
            fault = 1'b0;
            lo = '{bx.min_x, bx.min_y, bx.min_z};
            hi = '{bx.max_x, bx.max_y, bx.max_z};
            for (int a = 0; a < 3; a++) begin
                bmin[a] = 64'sd2147483647;
                bmax[a] = -64'sd2147483648;
            end
            for (int k = 0; k < CORNER_COUNT; k++) begin
                for (int a = 0; a < 3; a++) pt[a] = k[a] ? hi[a] : lo[a];
                for (int row = 0; row < 4; row++)
                    acc[row] = mul_down(entry(0, row), pt[0]) + mul_down(entry(1, row), pt[1])
                             + mul_down(entry(2, row), pt[2]) + entry(3, row);
                for (int a = 0; a < 3; a++) begin
                    v = divide(acc[a], acc[3], fault);
                    if (v < bmin[a]) bmin[a] = v;
                    if (v > bmax[a]) bmax[a] = v;
                end
            end
            res.min_x = bmin[0][31:0]; res.min_y = bmin[1][31:0]; res.min_z = bmin[2][31:0];
            res.max_x = bmax[0][31:0]; res.max_y = bmax[1][31:0]; res.max_z = bmax[2][31:0];
            res.fault = fault;
            pending.push_back(res);
        endfunction

        task check_result(t_result got);
            t_result e;
            if (pending.size() == 0) begin
                report("unexpected item", got.min_x, 32'd0);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.min_x !== e.min_x) report("out_min_x", got.min_x, e.min_x);
            if (got.min_y !== e.min_y) report("out_min_y", got.min_y, e.min_y);
            if (got.min_z !== e.min_z) report("out_min_z", got.min_z, e.min_z);
            if (got.max_x !== e.max_x) report("out_max_x", got.max_x, e.max_x);
            if (got.max_y !== e.max_y) report("out_max_y", got.max_y, e.max_y);
            if (got.max_z !== e.max_z) report("out_max_z", got.max_z, e.max_z);
            if (got.fault !== e.fault) report("divide_fault", got.fault, e.fault);
        endtask
    endclass

    box_scoreboard sb = new();

    bit   calm;        // no idling in the closing stretch
    bit   hold_pop;    // long receiver hold-off
    int   sent_boxes;
    int   cfg_phases;

    // Receiver: pop with random stalls
    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            if (hold_pop) begin
                i_pop <= 1'b0;
                repeat (150) @(negedge i_clk);
                hold_pop = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 11);
                i_pop <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && i_pop && !o_empty) begin
            r = '{o_out_min_x, o_out_min_y, o_out_min_z, o_out_max_x, o_out_max_y,
                  o_out_max_z, o_divide_fault};
            sb.check_result(r);
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            2:       return 32'($signed($urandom_range(0, 64)) - 32) <<< 16;
            default: return 32'($signed($urandom_range(0, 4000)) - 2000) <<< 12;
        endcase
    endfunction

    // Leaves i_push high on return; wait_idle drops it, and the next call may drop it for a gap
    task automatic push_box(input t_box bx);
        if (!calm && $urandom_range(0, 6) == 0) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        {i_min_x, i_min_y, i_min_z, i_max_x, i_max_y, i_max_z} <= bx;
        i_push <= 1'b1;
        do @(posedge i_clk); while (o_full);
        sb.note_box(bx);
        sent_boxes++;
        @(negedge i_clk);
    endtask

    task automatic push_random_box();
        t_box bx;
        bx = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        // mostly well-ordered boxes, some reversed
        if ($urandom_range(0, 3) != 0) begin
            if (bx.min_x > bx.max_x) {bx.min_x, bx.max_x} = {bx.max_x, bx.min_x};
            if (bx.min_y > bx.max_y) {bx.min_y, bx.max_y} = {bx.max_y, bx.min_y};
            if (bx.min_z > bx.max_z) {bx.min_z, bx.max_z} = {bx.max_z, bx.min_z};
        end
        push_box(bx);
    endtask

    // Drain outstanding results, then let the lanes settle before a write
    task automatic wait_idle();
        i_push <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_pair(input int idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= IDX_W'(idx);
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx < PAIR_COUNT) sb.pairs[idx] = val;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 4))
            0:       return $urandom();
            1:       return 32'h0001_0000;
            2:       return 32'd0;
            default: return 32'($signed($urandom_range(0, 8192)) - 4096) <<< 5;
        endcase
    endfunction

    task automatic load_matrix(input int mode);
        logic [63:0] v;
        for (int i = 0; i < PAIR_COUNT; i++) begin
            case (mode)
                0: v = {32'h7fff_ffff, 32'h8000_0000};                  // extremes
                1: v = {rand_entry(), rand_entry()};
                2: v = (i == 7) ? 64'd0 : sb.pairs[i];                    // w row zero
                default: v = {$urandom(), $urandom()};
            endcase
            write_pair(i, v);
        end
        write_pair(8 + $urandom_range(0, 7), {$urandom(), $urandom()}); // ignored index
        cfg_phases++;
    endtask

    initial begin
        t_box dir [$];
        sb.load_identity();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, zero, reversed and unit boxes under identity
        dir.push_back({6{32'h0000_0000}});
        dir.push_back({6{32'h7fff_ffff}});
        dir.push_back({6{32'h8000_0000}});
        dir.push_back({{3{32'h8000_0000}}, {3{32'h7fff_ffff}}});
        dir.push_back({{3{32'h7fff_ffff}}, {3{32'h8000_0000}}});
        dir.push_back({{3{32'hffff_0000}}, {3{32'h0001_0000}}});
        dir.push_back({{3{32'hffff_ffff}}, {3{32'h0000_0001}}});
        dir.push_back({32'h0001_8000, 32'hfffe_8000, 32'h5555_5555,
                       32'haaaa_aaaa, 32'h0000_ffff, 32'hffff_0001});
        foreach (dir[i]) push_box(dir[i]);
        wait_idle();
        // zero w: identity with w row cleared gives the fault, signs decide saturation
        load_matrix(2);
        foreach (dir[i]) push_box(dir[i]);
        wait_idle();
        load_matrix(0);
        foreach (dir[i]) push_box(dir[i]);

        // random phases
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            if (ph == 0) begin
                for (int i = 0; i < PAIR_COUNT; i++) write_pair(i, ONE_LO << (32 * (i % 2)) & (
                    (i == 0 || i == 5) ? ONE_LO : (i == 2 || i == 7) ? ONE_HI : 64'd0));
                cfg_phases++;
            end else begin
                load_matrix(ph == 5 ? 3 : 1);
            end
            if (ph == 2) hold_pop = 1'b1;
            if (ph == 5) calm = 1'b1;
            repeat (120) push_random_box();
        end

        wait_idle();
        $display("Covered %0d boxes across %0d matrix settings, including zero w and extremes.",
                 sent_boxes, cfg_phases);
        $display("Checked %0d results.", sb.checked);
        if (err_count == 0 && sb.pending.size() == 0)
            $display("** aabb_matrix_transform: PASSED **");
        else
            $display("** aabb_matrix_transform: FAILED **");
        $finish;
    end

    initial begin
        #400000;
        $display("Timeout with %0d results outstanding", sb.pending.size());
        $display("** aabb_matrix_transform: FAILED **");
        $finish;
    end

endmodule
